FILE: rtl/etp_pkg.sv
package etp_pkg;

    localparam int FUNC_ID_W   = 4;
    localparam int TS_W        = 32;
    localparam int CNT_W       = 5;
    localparam int DUMP_LIMIT  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int MAX_FUNCTIONS_DEF = 16;
    localparam int STACK_DEPTH_DEF   = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-3:0] REG_NUM_FUNCTIONS   = '0;
    localparam logic [CNT_W-1:0]  NUM_FUNCTIONS_RESET = CNT_W'(16);
    localparam logic [TS_W-1:0]   TS_SAT              = '1;

    typedef struct packed {
        logic [FUNC_ID_W-1:0] func_id;
        logic                 is_start;
        logic [TS_W-1:0]      timestamp;
        logic                 last_event;
        logic                 bad_id;
    } etp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP_RD,
        ST_DUMP_WR
    } back_state_t;

    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cfg,
                                                      input int unsigned max_fn);
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] n;
        lim = (max_fn < DUMP_LIMIT) ? CNT_W'(max_fn) : CNT_W'(DUMP_LIMIT);
        n   = cfg;
        if (n > lim)
        begin
            n = lim;
        end
        if (n == '0)
        begin
            n = CNT_W'(1);
        end
        return n;
    endfunction

endpackage

FILE: rtl/etp_event_if.sv
interface etp_event_if
    import etp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FUNC_ID_W-1:0] func_id;
    logic                 is_start;
    logic [TS_W-1:0]      timestamp;
    logic                 last_event;

    modport source (output valid, func_id, is_start, timestamp, last_event, input ready);
    modport sink (input valid, func_id, is_start, timestamp, last_event, output ready);
endinterface

FILE: rtl/etp_result_if.sv
interface etp_result_if
    import etp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FUNC_ID_W-1:0] result_func;
    logic [TS_W-1:0]      excl_total;
    logic                 last_result;
    logic                 trace_error;

    modport source (output valid, result_func, excl_total, last_result, trace_error,
                    input ready);
    modport sink (input valid, result_func, excl_total, last_result, trace_error,
                  output ready);
endinterface

FILE: rtl/exclusive_time_profiler.sv
// Exclusive-time profiler for a stream of function entry and exit events.
// Events arrive on the events channel (valid/ready) in timestamp order. Each
// event is taken into a two-entry queue and then worked off in ST_IDLE,
// which takes the stack top and reads the accumulator, and ST_EXEC, which
// writes them back; the back end pops a new event from the queue only once
// the last one has been written back.
// An event with last_event set is processed and then starts a dump: one
// result per function id in use, in id order, on the results channel. From
// ST_EXEC the block goes to ST_DUMP_RD, which reads a total, and ST_DUMP_WR,
// which loads it into the output register once that is free, per id. While
// the receiver stalls, the result waits in the output register and the queue
// takes events until its two entries are full. After the dump the totals,
// stack, mark and error flag are clear. The num_functions register sits at
// APB address 0 and must be written only while the block is idle; the block
// itself does not enforce this. Reset clears the totals, stack, mark and
// error flag at once, sets num_functions to 16 and leaves events.ready high.
module exclusive_time_profiler
    import etp_pkg::*;
#(
    parameter int MAX_FUNCTIONS = MAX_FUNCTIONS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    etp_event_if.sink         events,
    etp_result_if.source      results,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CNT_W-1:0] num_functions_reg;
    logic [CNT_W-1:0] num_functions_next;
    logic [CNT_W-1:0] n_active;
    logic             reg_hit;
    etp_item_t        head;
    logic             head_valid;
    logic             pop;

    assign pready   = 1'b1;
    assign reg_hit  = (paddr[APB_AW-1:2] == REG_NUM_FUNCTIONS);
    assign prdata   = reg_hit ? APB_DW'(num_functions_reg) : '0;
    assign n_active = active_count(num_functions_reg, MAX_FUNCTIONS);

    always_comb
    begin
        num_functions_next = num_functions_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            num_functions_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_functions_reg <= NUM_FUNCTIONS_RESET;
        end
        else
        begin
            num_functions_reg <= num_functions_next;
        end
    end

    etp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .events     (events),
        .n_active   (n_active),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    etp_back #(
        .MAX_FUNCTIONS (MAX_FUNCTIONS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_active   (n_active),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .results    (results)
    );

    // Every reported id lies within the ids in use.
    a_func_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ({1'b0, results.result_func} < n_active))
        else $error("result id beyond active function count");

    // The final result of a dump carries the highest id in use.
    a_last_is_top: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_result) |->
        ({1'b0, results.result_func} + CNT_W'(1) == n_active))
        else $error("last result flag on wrong id");

    // A dump does not restart at id zero before its last result has been taken.
    a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && !results.last_result) |=>
        (!results.valid || results.result_func != '0))
        else $error("dump restarted before its last result");

endmodule

FILE: rtl/etp_front.sv
module etp_front
    import etp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    etp_event_if.sink         events,
    input  logic [CNT_W-1:0]  n_active,
    output etp_item_t         head,
    output logic              head_valid,
    input  logic              pop
);

    etp_item_t  q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       take;
    etp_item_t  incoming;

    assign events.ready = (fill_reg != 2'(QUEUE_DEPTH));
    assign push         = events.valid && events.ready;
    assign head_valid   = (fill_reg != 2'd0);
    assign take         = pop && head_valid;
    assign head         = q_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.func_id    = events.func_id;
        incoming.is_start   = events.is_start;
        incoming.timestamp  = events.timestamp;
        incoming.last_event = events.last_event;
        incoming.bad_id     = ({1'b0, events.func_id} >= n_active);
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

FILE: rtl/etp_back.sv
module etp_back
    import etp_pkg::*;
#(
    parameter int MAX_FUNCTIONS = MAX_FUNCTIONS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  n_active,
    input  etp_item_t         head,
    input  logic              head_valid,
    output logic              pop,
    etp_result_if.source      results
);

    localparam int ACC_DEPTH = (MAX_FUNCTIONS < DUMP_LIMIT) ? MAX_FUNCTIONS : DUMP_LIMIT;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int SCW       = $clog2(STACK_DEPTH + 1);
    localparam int SAW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    back_state_t          state_reg;
    back_state_t          state_next;
    etp_item_t            item_reg;
    etp_item_t            item_next;
    logic [TS_W-1:0]      amount_reg;
    logic [TS_W-1:0]      amount_next;
    logic                 charge_reg;
    logic                 charge_next;
    logic [ACC_AW-1:0]    acc_addr_reg;
    logic [ACC_AW-1:0]    acc_addr_next;
    logic [SCW-1:0]       count_reg;
    logic [SCW-1:0]       count_next;
    logic [TS_W-1:0]      mark_reg;
    logic [TS_W-1:0]      mark_next;
    logic                 err_reg;
    logic                 err_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [ACC_DEPTH-1:0] vld_reg;
    logic [ACC_DEPTH-1:0] vld_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [FUNC_ID_W-1:0] out_func_reg;
    logic [TS_W-1:0]      out_total_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;
    logic                 out_load;

    logic [TS_W-1:0]      acc_mem [ACC_DEPTH];
    logic [TS_W-1:0]      acc_rd_reg;
    logic                 acc_rd_vld_reg;
    logic [ACC_AW-1:0]    acc_raddr;
    logic                 acc_we;
    logic [TS_W-1:0]      acc_wdata;

    logic [FUNC_ID_W-1:0] stack_mem [STACK_DEPTH];
    logic [FUNC_ID_W-1:0] stack_top_reg;
    logic [SAW-1:0]       st_raddr;
    logic [SAW-1:0]       st_waddr;
    logic                 st_we;
    logic [SCW-1:0]       top_index;

    logic [TS_W-1:0]      elapsed;
    logic [TS_W-1:0]      cur_total;
    logic [TS_W:0]        sum;

    assign results.valid       = out_valid_reg;
    assign results.result_func = out_func_reg;
    assign results.excl_total  = out_total_reg;
    assign results.last_result = out_last_reg;
    assign results.trace_error = out_err_reg;

    assign cur_total = acc_rd_vld_reg ? acc_rd_reg : '0;
    assign sum       = {1'b0, cur_total} + {1'b0, amount_reg};
    assign acc_wdata = sum[TS_W] ? TS_SAT : sum[TS_W-1:0];
    assign elapsed   = (head.timestamp >= mark_reg) ? (head.timestamp - mark_reg) : '0;
    assign st_waddr  = count_reg[SAW-1:0];
    assign top_index = count_next - SCW'(1);
    assign st_raddr  = top_index[SAW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        amount_next    = amount_reg;
        charge_next    = charge_reg;
        acc_addr_next  = acc_addr_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        vld_next       = vld_reg;
        pop            = 1'b0;
        acc_raddr      = acc_addr_reg;
        acc_we         = 1'b0;
        st_we          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    state_next = ST_EXEC;
                    if (head.bad_id)
                    begin
                        charge_next = 1'b0;
                    end
                    else if (head.is_start)
                    begin
                        charge_next   = (count_reg != '0) && (count_reg < SCW'(STACK_DEPTH));
                        acc_addr_next = stack_top_reg[ACC_AW-1:0];
                        amount_next   = elapsed;
                    end
                    else
                    begin
                        charge_next   = 1'b1;
                        acc_addr_next = head.func_id[ACC_AW-1:0];
                        amount_next   = (elapsed == TS_SAT) ? TS_SAT : elapsed + 1'b1;
                    end
                    acc_raddr = acc_addr_next;
                end
            end
            ST_EXEC:
            begin
                if (charge_reg)
                begin
                    acc_we                 = 1'b1;
                    vld_next[acc_addr_reg] = 1'b1;
                end
                if (item_reg.bad_id)
                begin
                    err_next = 1'b1;
                end
                else if (item_reg.is_start)
                begin
                    if (count_reg == SCW'(STACK_DEPTH))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        mark_next  = item_reg.timestamp;
                        st_we      = 1'b1;
                        count_next = count_reg + SCW'(1);
                    end
                end
                else
                begin
                    mark_next = (item_reg.timestamp == TS_SAT) ? TS_SAT
                                                               : item_reg.timestamp + 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - SCW'(1);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                if (item_reg.last_event)
                begin
                    idx_next   = '0;
                    state_next = ST_DUMP_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                acc_raddr  = idx_reg[ACC_AW-1:0];
                state_next = ST_DUMP_WR;
            end
            ST_DUMP_WR:
            begin
                acc_raddr = idx_reg[ACC_AW-1:0];
                if (!out_valid_reg || results.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (idx_reg + CNT_W'(1) == n_active)
                    begin
                        vld_next   = '0;
                        count_next = '0;
                        mark_next  = '0;
                        err_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mark_reg      <= '0;
            err_reg       <= 1'b0;
            vld_reg       <= '0;
            idx_reg       <= '0;
            charge_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            err_reg       <= err_next;
            vld_reg       <= vld_next;
            idx_reg       <= idx_next;
            charge_reg    <= charge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        amount_reg   <= amount_next;
        acc_addr_reg <= acc_addr_next;
        if (out_load)
        begin
            out_func_reg  <= idx_reg[FUNC_ID_W-1:0];
            out_total_reg <= cur_total;
            out_last_reg  <= (idx_reg + CNT_W'(1) == n_active);
            out_err_reg   <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_addr_reg] <= acc_wdata;
        end
        acc_rd_reg     <= acc_mem[acc_raddr];
        acc_rd_vld_reg <= vld_reg[acc_raddr] && !(acc_we && acc_addr_reg == acc_raddr);
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_waddr] <= item_reg.func_id;
        end
        if (st_we && st_waddr == st_raddr)
        begin
            stack_top_reg <= item_reg.func_id;
        end
        else
        begin
            stack_top_reg <= stack_mem[st_raddr];
        end
    end

endmodule
